[sv/gfs_pkg.sv]
// ----------------------------------------------------------------------------
// gfs_pkg
// Shared types and constants of the grid fire spread step block.
// ----------------------------------------------------------------------------
package gfs_pkg;

    // Default store dimensions and cell width.
    localparam int DEF_MAX_ROWS  = 64;
    localparam int DEF_MAX_COLS  = 64;
    localparam int DEF_CELL_BITS = 3;

    // Fixed field widths of the channels.
    localparam int REQ_W    = 2;
    localparam int ADDR_W   = 6;
    localparam int VALUE_W  = 3;
    localparam int COUNT_W  = 13;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;

    // Request kinds carried in s_tuser.
    localparam logic [REQ_W-1:0] REQ_WRITE   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_READ    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_ADVANCE = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIND_ON      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WIND_MASK    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_HEALTHY = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_BURNING = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_BURNT   = 3'd6;

    // Bits of the wind mask, named by the direction the fire travels.
    localparam int DIR_UP    = 0;
    localparam int DIR_DOWN  = 1;
    localparam int DIR_LEFT  = 2;
    localparam int DIR_RIGHT = 3;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 13'h1fff;

    // Which neighbors of the current cell may pass fire to it.
    typedef struct packed {
        logic from_up;
        logic from_down;
        logic from_left;
        logic from_right;
    } gfs_nbr_t;

endpackage

[sv/gfs_cell_rule.sv]
// ----------------------------------------------------------------------------
// gfs_cell_rule
// Next-generation code of one cell from its old value and four neighbors.
// ----------------------------------------------------------------------------
module gfs_cell_rule #(
    parameter int CELL_BITS = gfs_pkg::DEF_CELL_BITS
) (
    input  logic [CELL_BITS-1:0] old_cell,
    input  logic [CELL_BITS-1:0] up_cell,
    input  logic [CELL_BITS-1:0] down_cell,
    input  logic [CELL_BITS-1:0] left_cell,
    input  logic [CELL_BITS-1:0] right_cell,
    input  logic [CELL_BITS-1:0] code_heal,
    input  logic [CELL_BITS-1:0] code_burn,
    input  logic [CELL_BITS-1:0] code_dead,
    input  gfs_pkg::gfs_nbr_t    nbr,
    output logic [CELL_BITS-1:0] next_cell
);
    import gfs_pkg::*;

    logic early;
    logic late;

    // Fire from below or the right is applied before the burning check and fire
    // from above or the left after it, as in raster order with equal codes.
    assign early = (nbr.from_up && (up_cell == code_burn))
                || (nbr.from_left && (left_cell == code_burn));
    assign late  = (nbr.from_down && (down_cell == code_burn))
                || (nbr.from_right && (right_cell == code_burn));

    always_comb
    begin
        priority if ((old_cell == code_heal) && late)
        begin
            next_cell = code_burn;
        end
        else if (old_cell == code_burn)
        begin
            next_cell = code_dead;
        end
        else if ((old_cell == code_heal) && early)
        begin
            next_cell = code_burn;
        end
        else
        begin
            next_cell = old_cell;
        end
    end

endmodule

[sv/gfs_store.sv]
// ----------------------------------------------------------------------------
// gfs_store
// Cell grid memory with two read ports and one write port, and the line
// buffer that keeps the old contents of the row above during a sweep.
// ----------------------------------------------------------------------------
module gfs_store #(
    parameter int MAX_ROWS  = gfs_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS  = gfs_pkg::DEF_MAX_COLS,
    parameter int CELL_BITS = gfs_pkg::DEF_CELL_BITS,
    localparam int GDEPTH   = MAX_ROWS * MAX_COLS,
    localparam int GAW      = (GDEPTH > 1) ? $clog2(GDEPTH) : 1,
    localparam int CIW      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
    input  logic                 clk,
    input  logic                 g_we,
    input  logic [GAW-1:0]       g_waddr,
    input  logic [CELL_BITS-1:0] g_wdata,
    input  logic [GAW-1:0]       g_raddr_a,
    input  logic [GAW-1:0]       g_raddr_b,
    output logic [CELL_BITS-1:0] g_qa,
    output logic [CELL_BITS-1:0] g_qb,
    input  logic                 l_we,
    input  logic [CIW-1:0]       l_waddr,
    input  logic [CELL_BITS-1:0] l_wdata,
    input  logic [CIW-1:0]       l_raddr,
    output logic [CELL_BITS-1:0] l_q
);
    import gfs_pkg::*;

    logic [CELL_BITS-1:0] grid_mem  [GDEPTH];
    logic [CELL_BITS-1:0] above_mem [MAX_COLS];

    always_ff @(posedge clk)
    begin
        if (g_we)
        begin
            grid_mem[g_waddr] <= g_wdata;
        end
        g_qa <= grid_mem[g_raddr_a];
        g_qb <= grid_mem[g_raddr_b];
    end

    always_ff @(posedge clk)
    begin
        if (l_we)
        begin
            above_mem[l_waddr] <= l_wdata;
        end
        l_q <= above_mem[l_raddr];
    end

endmodule

[sv/grid_fire_spread_step_top.sv]
// ----------------------------------------------------------------------------
// grid_fire_spread_step_top
// Forest fire cellular automaton: cell writes, cell reads and generation steps
// on a grid held in one memory.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+----------------------------------
//  s_*      | in        | s_tvalid/s_tready  | tuser: req_type; tdata: row,col,
//           |           |                    |        cell_value
//  m_*      | out       | m_tvalid/m_tready  | tdata: read_value, burning_count
//  cfg_*    | in        | cfg_we             | cfg_index, cfg_data
//
// A write's beat is loaded as the write is taken; a read passes through ST_READ,
// where the registered memory output forms its beat. During an advance the sweep
// visits one cell per cycle through the single rule unit, fed by the two grid
// read ports, and each row runs past its last column to drain the read latency
// and the right neighbor. Reset only sets registers; the grid is not cleared,
// so every cell must be written before it is read; the block does not enforce this.
// A stalled result beat holds in the output register; s_tready stays low
// while that register cannot take the next result.
// ----------------------------------------------------------------------------
module grid_fire_spread_step_top #(
    parameter int MAX_ROWS  = gfs_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS  = gfs_pkg::DEF_MAX_COLS,
    parameter int CELL_BITS = gfs_pkg::DEF_CELL_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [5:0] row, [11:6] col, [14:12] cell_value, [15] zero
    input  logic [gfs_pkg::S_DATA_W-1:0]    s_tdata,
    // [1:0] req_type
    input  logic [gfs_pkg::REQ_W-1:0]       s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [2:0] read_value, [15:3] burning_count
    output logic [gfs_pkg::M_DATA_W-1:0]    m_tdata,
    input  logic                            cfg_we,
    input  logic [gfs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gfs_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import gfs_pkg::*;

    localparam int GDEPTH = MAX_ROWS * MAX_COLS;
    localparam int GAW    = (GDEPTH > 1) ? $clog2(GDEPTH) : 1;
    localparam int RIW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CIW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RCW    = $clog2(MAX_ROWS + 1);
    localparam int CCW    = $clog2(MAX_COLS + 1);
    localparam int KW     = $clog2(MAX_COLS + 2);
    localparam logic [10:0] MAX_ROWS_W = 11'(MAX_ROWS);
    localparam logic [10:0] MAX_COLS_W = 11'(MAX_COLS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SWEEP
    } state_t;

    function automatic logic [GAW-1:0] grid_addr(input logic [RIW-1:0] r,
                                                 input logic [CIW-1:0] c);
        return GAW'(int'(r) * MAX_COLS + int'(c));
    endfunction

    function automatic logic [CELL_BITS-1:0] to_cell(input logic [VALUE_W-1:0] v);
        logic [CELL_BITS+VALUE_W-1:0] wide;
        wide = {{CELL_BITS{1'b0}}, v};
        return wide[CELL_BITS-1:0];
    endfunction

    function automatic logic [VALUE_W-1:0] from_cell(input logic [CELL_BITS-1:0] v);
        logic [CELL_BITS+VALUE_W-1:0] wide;
        wide = {{VALUE_W{1'b0}}, v};
        return wide[VALUE_W-1:0];
    endfunction

    state_t state_reg;

    logic [6:0]           grid_rows_reg;
    logic [6:0]           grid_cols_reg;
    logic                 wind_on_reg;
    logic [3:0]           wind_mask_reg;
    logic [VALUE_W-1:0]   code_healthy_reg;
    logic [VALUE_W-1:0]   code_burning_reg;
    logic [VALUE_W-1:0]   code_burnt_reg;

    logic [RCW-1:0]       rows_reg;
    logic [CCW-1:0]       cols_reg;
    logic [3:0]           dirs_reg;
    logic [CELL_BITS-1:0] heal_reg;
    logic [CELL_BITS-1:0] burn_reg;
    logic [CELL_BITS-1:0] dead_reg;
    logic [RIW-1:0]       row_reg;
    logic [KW-1:0]        k_reg;
    logic [COUNT_W-1:0]   count_reg;
    logic [CELL_BITS-1:0] cur_reg;
    logic [CELL_BITS-1:0] left_reg;
    logic [CELL_BITS-1:0] down_reg;
    logic [CELL_BITS-1:0] up_reg;
    logic                 rd_inside_reg;
    logic                 m_valid_reg;
    logic [M_DATA_W-1:0]  m_data_reg;

    logic [REQ_W-1:0]     req_type;
    logic [ADDR_W-1:0]    req_row;
    logic [ADDR_W-1:0]    req_col;
    logic [VALUE_W-1:0]   req_value;
    logic [15:0]          req_row_w;
    logic [15:0]          req_col_w;
    logic                 req_inside;
    logic [GAW-1:0]       req_addr;
    logic                 accept;
    logic                 result_load;

    logic [10:0]          rows_w;
    logic [10:0]          cols_w;
    logic [10:0]          rows_clamp;
    logic [10:0]          cols_clamp;

    logic                 eval;
    logic                 k_in;
    logic [CIW-1:0]       k_col;
    logic [CIW-1:0]       e_col;
    logic                 down_ok;
    logic [RIW-1:0]       row_b;
    logic                 k_last;
    gfs_nbr_t             nbr;
    logic [CELL_BITS-1:0] cell_next;
    logic [COUNT_W-1:0]   count_next;

    logic                 g_we;
    logic [GAW-1:0]       g_waddr;
    logic [CELL_BITS-1:0] g_wdata;
    logic [GAW-1:0]       g_raddr_a;
    logic [GAW-1:0]       g_raddr_b;
    logic [CELL_BITS-1:0] g_qa;
    logic [CELL_BITS-1:0] g_qb;
    logic [CELL_BITS-1:0] l_q;

    // Request decode.
    assign req_type  = s_tuser;
    assign req_row   = s_tdata[ADDR_W-1:0];
    assign req_col   = s_tdata[2*ADDR_W-1:ADDR_W];
    assign req_value = s_tdata[2*ADDR_W+VALUE_W-1:2*ADDR_W];
    assign req_row_w = {{(16-ADDR_W){1'b0}}, req_row};
    assign req_col_w = {{(16-ADDR_W){1'b0}}, req_col};
    assign req_inside = (req_row_w[10:0] < MAX_ROWS_W) && (req_col_w[10:0] < MAX_COLS_W);
    assign req_addr   = grid_addr(req_row_w[RIW-1:0], req_col_w[CIW-1:0]);

    // The output register must be free by the next edge to take a result.
    assign s_tready = (state_reg == ST_IDLE) && (!m_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // A new result beat enters the output register in this cycle.
    assign result_load = (state_reg == ST_READ)
                      || ((state_reg == ST_IDLE) && accept
                          && (req_type != REQ_READ) && (req_type != REQ_ADVANCE))
                      || ((state_reg == ST_SWEEP) && k_last && !down_ok);

    // Size registers saturate into the store; a size of zero counts as one.
    assign rows_w = {4'b0, grid_rows_reg};
    assign cols_w = {4'b0, grid_cols_reg};

    always_comb
    begin
        priority if (rows_w == 11'd0)
        begin
            rows_clamp = 11'd1;
        end
        else if (rows_w > MAX_ROWS_W)
        begin
            rows_clamp = MAX_ROWS_W;
        end
        else
        begin
            rows_clamp = rows_w;
        end
    end

    always_comb
    begin
        priority if (cols_w == 11'd0)
        begin
            cols_clamp = 11'd1;
        end
        else if (cols_w > MAX_COLS_W)
        begin
            cols_clamp = MAX_COLS_W;
        end
        else
        begin
            cols_clamp = cols_w;
        end
    end

    // Sweep: column k is fetched while cell k-2 is updated, so the cell under
    // update sees its right neighbor straight from the read port.
    assign k_in    = int'(k_reg) < int'(cols_reg);
    assign k_col   = k_in ? k_reg[CIW-1:0] : '0;
    assign e_col   = CIW'(int'(k_reg) - 2);
    assign eval    = (state_reg == ST_SWEEP) && (int'(k_reg) >= 2);
    assign down_ok = (int'(row_reg) + 1) < int'(rows_reg);
    assign row_b   = down_ok ? RIW'(int'(row_reg) + 1) : row_reg;
    assign k_last  = int'(k_reg) == (int'(cols_reg) + 1);

    assign nbr.from_up    = (row_reg != '0) && dirs_reg[DIR_DOWN];
    assign nbr.from_left  = (e_col != '0) && dirs_reg[DIR_RIGHT];
    assign nbr.from_down  = down_ok && dirs_reg[DIR_UP];
    assign nbr.from_right = ((int'(e_col) + 1) < int'(cols_reg)) && dirs_reg[DIR_LEFT];

    gfs_cell_rule #(
        .CELL_BITS (CELL_BITS)
    ) u_rule (
        .old_cell   (cur_reg),
        .up_cell    (up_reg),
        .down_cell  (down_reg),
        .left_cell  (left_reg),
        .right_cell (g_qa),
        .code_heal  (heal_reg),
        .code_burn  (burn_reg),
        .code_dead  (dead_reg),
        .nbr        (nbr),
        .next_cell  (cell_next)
    );

    assign count_next = (eval && (cell_next == burn_reg) && (count_reg != COUNT_MAX))
                      ? count_reg + 1'b1 : count_reg;

    // Memory port selection.
    assign g_we      = eval || (accept && (req_type == REQ_WRITE) && req_inside);
    assign g_waddr   = eval ? grid_addr(row_reg, e_col) : req_addr;
    assign g_wdata   = eval ? cell_next : to_cell(req_value);
    assign g_raddr_a = (state_reg == ST_SWEEP) ? grid_addr(row_reg, k_col) : req_addr;
    assign g_raddr_b = grid_addr(row_b, k_col);

    gfs_store #(
        .MAX_ROWS  (MAX_ROWS),
        .MAX_COLS  (MAX_COLS),
        .CELL_BITS (CELL_BITS)
    ) u_store (
        .clk       (clk),
        .g_we      (g_we),
        .g_waddr   (g_waddr),
        .g_wdata   (g_wdata),
        .g_raddr_a (g_raddr_a),
        .g_raddr_b (g_raddr_b),
        .g_qa      (g_qa),
        .g_qb      (g_qb),
        .l_we      (eval),
        .l_waddr   (e_col),
        .l_wdata   (cur_reg),
        .l_raddr   (k_col),
        .l_q       (l_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            grid_rows_reg    <= 7'd64;
            grid_cols_reg    <= 7'd64;
            wind_on_reg      <= 1'b0;
            wind_mask_reg    <= 4'hf;
            code_healthy_reg <= 3'd1;
            code_burning_reg <= 3'd2;
            code_burnt_reg   <= 3'd3;
            rows_reg         <= '0;
            cols_reg         <= '0;
            dirs_reg         <= '0;
            heal_reg         <= '0;
            burn_reg         <= '0;
            dead_reg         <= '0;
            row_reg          <= '0;
            k_reg            <= '0;
            count_reg        <= '0;
            cur_reg          <= '0;
            left_reg         <= '0;
            down_reg         <= '0;
            up_reg           <= '0;
            rd_inside_reg    <= 1'b0;
            m_valid_reg      <= 1'b0;
            m_data_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_GRID_ROWS:    grid_rows_reg    <= cfg_data;
                    CFG_GRID_COLS:    grid_cols_reg    <= cfg_data;
                    CFG_WIND_ON:      wind_on_reg      <= cfg_data[0];
                    CFG_WIND_MASK:    wind_mask_reg    <= cfg_data[3:0];
                    CFG_CODE_HEALTHY: code_healthy_reg <= cfg_data[VALUE_W-1:0];
                    CFG_CODE_BURNING: code_burning_reg <= cfg_data[VALUE_W-1:0];
                    CFG_CODE_BURNT:   code_burnt_reg   <= cfg_data[VALUE_W-1:0];
                    default:          ;
                endcase
            end

            if (result_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_valid_reg && m_tready)
            begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        unique case (req_type)
                            REQ_READ:
                            begin
                                rd_inside_reg <= req_inside;
                                state_reg     <= ST_READ;
                            end
                            REQ_ADVANCE:
                            begin
                                rows_reg  <= rows_clamp[RCW-1:0];
                                cols_reg  <= cols_clamp[CCW-1:0];
                                dirs_reg  <= wind_on_reg ? wind_mask_reg : 4'hf;
                                heal_reg  <= to_cell(code_healthy_reg);
                                burn_reg  <= to_cell(code_burning_reg);
                                dead_reg  <= to_cell(code_burnt_reg);
                                row_reg   <= '0;
                                k_reg     <= '0;
                                count_reg <= '0;
                                state_reg <= ST_SWEEP;
                            end
                            default:
                            begin
                                // Writes and unused kinds answer with an all-zero beat.
                                m_data_reg  <= '0;
                            end
                        endcase
                    end
                end
                ST_READ:
                begin
                    m_data_reg  <= {{COUNT_W{1'b0}},
                                    rd_inside_reg ? from_cell(g_qa) : {VALUE_W{1'b0}}};
                    state_reg   <= ST_IDLE;
                end
                ST_SWEEP:
                begin
                    left_reg  <= cur_reg;
                    cur_reg   <= g_qa;
                    down_reg  <= g_qb;
                    up_reg    <= l_q;
                    count_reg <= count_next;
                    if (k_last)
                    begin
                        k_reg <= '0;
                        if (!down_ok)
                        begin
                            m_data_reg  <= {count_next, {VALUE_W{1'b0}}};
                            state_reg   <= ST_IDLE;
                        end
                        else
                        begin
                            row_reg <= RIW'(int'(row_reg) + 1);
                        end
                    end
                    else
                    begin
                        k_reg <= KW'(int'(k_reg) + 1);
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

[sv/gfs_checker.sv]
// ----------------------------------------------------------------------------
// gfs_checker
// Port-level checks of the grid fire spread step block, bound to its top.
// ----------------------------------------------------------------------------
module gfs_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [gfs_pkg::REQ_W-1:0]     s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [gfs_pkg::M_DATA_W-1:0]  m_tdata
);
    import gfs_pkg::*;

    // No request is taken while a result beat is stuck in the output register.
    a_no_accept_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("request accepted while result beat stalled");

    // A write answers in the next cycle with an all-zero beat.
    a_write_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser == REQ_WRITE)) |=> (m_tvalid && (m_tdata == '0)))
        else $error("write did not answer with a zero beat");

    // A read waits on the memory access before its beat shows.
    a_read_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser == REQ_READ)) |=> (!m_tvalid && !s_tready))
        else $error("read result or new request too early");

    // An advance sweeps the grid, so no request is taken in the next cycle.
    a_advance_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser == REQ_ADVANCE)) |=> !s_tready)
        else $error("request accepted during sweep");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result beat changed");

endmodule

bind grid_fire_spread_step_top gfs_checker u_gfs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
